// ===== hdl/ssnd_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number display package
// Shared opcodes, segment constants, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssnd_pkg;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_REFRESH = 2'd1,
    OP_CLEAR   = 2'd2
  } ssnd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_TEST   = 2'd1,
    ST_DIGIT  = 2'd2,
    ST_FINISH = 2'd3
  } ssnd_state_e;

  localparam logic [7:0]  PAT_OFF   = 8'hFF;
  localparam logic [7:0]  PAT_DOT   = 8'h7F;
  localparam logic [7:0]  PAT_MINUS = 8'hBF;

  // floor(n / 10) == (n * RECIP10) >> RECIP10_SHIFT for every 32-bit n.
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  typedef struct packed {
    logic load;     // capture a new value and point position
    logic blank;    // set every digit to all-off
    logic mul;      // register the quotient of the current magnitude
    logic digit;    // write one digit and shift the magnitude down
    logic finish;   // place the decimal point and the minus sign
    logic advance;  // step the scan pointer after a refresh
  } ssnd_cmd_t;

  typedef struct packed {
    logic loop_go;  // another digit has to be written
  } ssnd_stat_t;

  function automatic logic [7:0] ssnd_glyph(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = PAT_OFF;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/ssnd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number display controller
// Accepts items, sequences the digit conversion and issues datapath commands.
// ----------------------------------------------------------------------------
module ssnd_ctrl import ssnd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] op_i,
  input  logic       out_full_i,
  input  ssnd_stat_t stat_i,
  output logic       in_stall_o,
  output logic       push_o,
  output ssnd_cmd_t  cmd_o
);

  ssnd_state_e state_q, state_d;
  logic        accept;

  assign in_stall_o = (state_q != ST_IDLE) || out_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op_i == OP_SET)) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        state_d = stat_i.loop_go ? ST_DIGIT : ST_FINISH;
      end
      ST_DIGIT:  state_d = ST_TEST;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    push_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_SET: begin
              cmd_o.load  = 1'b1;
              cmd_o.blank = 1'b1;
            end
            OP_REFRESH: begin
              cmd_o.advance = 1'b1;
              push_o        = 1'b1;
            end
            OP_CLEAR: cmd_o.blank = 1'b1;
            default: ;
          endcase
        end
      end
      ST_TEST:   cmd_o.mul    = stat_i.loop_go;
      ST_DIGIT:  cmd_o.digit  = 1'b1;
      ST_FINISH: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> (state_q == ST_IDLE))
    else $error("controller did not return to idle after finishing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> ($past(state_q) == ST_TEST))
    else $error("digit write not preceded by a quotient step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (!out_full_i && (state_q == ST_IDLE)))
    else $error("refresh result pushed while busy or output full");
`endif

endmodule

// ===== hdl/ssnd_datapath.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number display datapath
// Holds the segment buffer, the scan pointer and the conversion registers.
// ----------------------------------------------------------------------------
module ssnd_datapath import ssnd_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssnd_cmd_t           cmd_i,
  input  logic signed [31:0]  number_i,
  input  logic        [3:0]   point_position_i,
  output ssnd_stat_t          stat_o,
  output logic        [2:0]   sel_o,
  output logic        [7:0]   pat_o
);

  localparam int IdxW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CntW = $clog2(DIGITS + 1);

  logic [7:0]      pat_q [DIGITS];
  logic [IdxW-1:0] scan_q;
  logic [31:0]     mag_q;
  logic [28:0]     quo_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] point_q;
  logic            neg_q;

  logic [31:0]     raw;
  logic [63:0]     prod;
  logic [31:0]     quo_ext;
  logic [31:0]     tens;
  logic [3:0]      rem;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] dot_idx;
  logic            point_ok;
  logic            cnt_room;

  assign raw      = $unsigned(number_i);
  assign point_ok = ({1'b0, point_position_i} < 5'(DIGITS));
  assign cnt_room = (5'(cnt_q) < 5'(DIGITS));

  assign stat_o.loop_go = ((mag_q != 32'd0) || (5'(cnt_q) <= 5'(point_q))) && cnt_room;

  assign prod    = 64'(mag_q) * 64'(RECIP10);
  assign quo_ext = 32'(quo_q);
  assign tens    = (quo_ext << 3) + (quo_ext << 1);
  assign rem     = 4'(mag_q - tens);

  // The count never reaches DIGITS where these addresses are used.
  assign wr_idx  = IdxW'(DIGITS - 1) - cnt_q[IdxW-1:0];
  assign dot_idx = IdxW'(DIGITS - 1) - point_q;

  assign sel_o = 3'(scan_q);
  assign pat_o = pat_q[scan_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q   <= raw[31] ? (32'd0 - raw) : raw;
      neg_q   <= raw[31];
      point_q <= point_ok ? IdxW'(point_position_i) : '0;
    end else if (cmd_i.digit) begin
      mag_q <= quo_ext;
    end
    if (cmd_i.mul) begin
      quo_q <= prod[63:RECIP10_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      scan_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.digit) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.advance) begin
        scan_q <= (scan_q == IdxW'(DIGITS - 1)) ? '0 : scan_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        pat_q[i] <= PAT_OFF;
      end
    end else begin
      for (int i = 0; i < DIGITS; i++) begin
        if (cmd_i.blank) begin
          pat_q[i] <= PAT_OFF;
        end else if (cmd_i.digit && (wr_idx == IdxW'(i))) begin
          pat_q[i] <= ssnd_glyph(rem);
        end else if (cmd_i.finish) begin
          // The sign lands left of every written digit, so it never meets the dot.
          if (neg_q && cnt_room && (wr_idx == IdxW'(i))) begin
            pat_q[i] <= PAT_MINUS;
          end else if ((point_q != '0) && (dot_idx == IdxW'(i))) begin
            pat_q[i] <= pat_q[i] & PAT_DOT;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/ssnd_out.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number display output stage
// Output register with one skid entry so a refresh can be taken while the
// previous result is still stalled.
// ----------------------------------------------------------------------------
module ssnd_out import ssnd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [2:0] sel_i,
  input  logic [7:0] pat_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [2:0] digit_select_o,
  output logic [7:0] segment_pattern_o,
  output logic       full_o
);

  logic       out_valid_q;
  logic [2:0] out_sel_q;
  logic [7:0] out_pat_q;
  logic       skid_valid_q;
  logic [2:0] skid_sel_q;
  logic [7:0] skid_pat_q;
  logic       pop;

  assign pop               = out_valid_q && !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign digit_select_o    = out_sel_q;
  assign segment_pattern_o = out_pat_q;
  assign full_o            = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_q  <= skid_valid_q || push_i;
        skid_valid_q <= 1'b0;
      end else if (push_i) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= out_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_sel_q <= skid_sel_q;
        out_pat_q <= skid_pat_q;
      end else if (push_i) begin
        out_sel_q <= sel_i;
        out_pat_q <= pat_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_sel_q <= sel_i;
        skid_pat_q <= pat_i;
      end else begin
        out_sel_q <= sel_i;
        out_pat_q <= pat_i;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("item pushed into a full output stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not moved into the output register");
`endif

endmodule

// ===== hdl/seven_segment_number_display_core.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number display core
// Converts signed values to segment patterns for a multiplexed display and
// returns one digit select and pattern for each refresh item.
// ----------------------------------------------------------------------------
//  Channel  Signals                                      Direction
//  input    in_valid_i, in_stall_o, op_i, number_i,     in
//           point_position_i
//  output   out_valid_o, out_stall_i, digit_select_o,   out
//           segment_pattern_o
//
//  A refresh or clear item is taken in the idle state; a refresh result goes
//  to the output register, or to its skid entry while that register stalls.
//  A set item writes at most DIGITS digits: it loads the value, then for each
//  digit registers the divide-by-ten quotient from the reciprocal multiply and
//  writes the digit, and last places the decimal point and the minus sign.
//  Reset blanks every digit and returns the scan pointer to digit 0.
//  Input is stalled while a set item converts, or while both the output
//  register and its skid entry hold unaccepted results.
// ----------------------------------------------------------------------------
module seven_segment_number_display_core import ssnd_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] number_i,
  input  logic [3:0]         point_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         digit_select_o,
  output logic [7:0]         segment_pattern_o
);

  ssnd_cmd_t  cmd;
  ssnd_stat_t stat;
  logic       push;
  logic       out_full;
  logic [2:0] sel;
  logic [7:0] pat;

  ssnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .out_full_i (out_full),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  ssnd_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .number_i         (number_i),
    .point_position_i (point_position_i),
    .stat_o           (stat),
    .sel_o            (sel),
    .pat_o            (pat)
  );

  ssnd_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .sel_i             (sel),
    .pat_i             (pat),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .digit_select_o    (digit_select_o),
    .segment_pattern_o (segment_pattern_o),
    .full_o            (out_full)
  );

endmodule

// ===== tb/sv/ssnd_scan_checker.sv =====
// ----------------------------------------------------------------------------
// Seven-segment display scan checker
// Watches both channels of the display core, keeps its own copy of the digit
// patterns and the scan pointer, and compares each scan result against the
// oldest predicted one.
// ----------------------------------------------------------------------------
module ssnd_scan_checker import ssnd_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] number_i,
  input  logic [3:0]         point_position_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         digit_select_i,
  input  logic [7:0]         segment_pattern_i,
  output int                 mismatches_o,
  output int                 outstanding_o,
  output int                 compared_o
);

  localparam int MAX_REPORTS = 10;

  typedef logic [DIGITS-1:0][7:0] panel_t;

  typedef struct packed {
    logic [2:0] select;
    logic [7:0] pattern;
  } scan_t;

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  panel_t      panel_q;
  int unsigned scan_pos_q;
  scan_t       scans_due_q [$];
  scan_t       due;
  int          mismatches;
  int          compared;

  // Entry 0 is the leftmost digit; digits are written from the right end.
  function automatic panel_t render_number(input logic [31:0] raw,
                                           input logic [3:0]  point_in);
    panel_t      p;
    logic        negative;
    logic [31:0] mag;
    int unsigned point;
    int unsigned written;
    negative = raw[31];
    mag      = negative ? (32'd0 - raw) : raw;
    point    = (point_in >= DIGITS) ? 0 : point_in;
    written  = 0;
    p        = {DIGITS{PAT_OFF}};
    while ((mag != 0 || written <= point) && written < DIGITS) begin
      p[DIGITS-1-written] = DIGIT_GLYPH[mag % 10];
      mag = mag / 10;
      written++;
    end
    if (point != 0) p[DIGITS-1-point] &= PAT_DOT;
    // The sign only shows when a digit position is left over for it.
    if (negative && written < DIGITS) p[DIGITS-1-written] = PAT_MINUS;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_q    = {DIGITS{PAT_OFF}};
      scan_pos_q = 0;
      scans_due_q.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      // A result accepted at this edge always belongs to an earlier item.
      if (out_valid_i && !out_stall_i) begin
        if (scans_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected scan result: select %0d pattern %02h",
                     digit_select_i, segment_pattern_i);
          end
        end else begin
          due = scans_due_q.pop_front();
          compared++;
          if (digit_select_i !== due.select || segment_pattern_i !== due.pattern) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("scan result %0d: select exp %0d act %0d, pattern exp %02h act %02h",
                       compared, due.select, digit_select_i, due.pattern,
                       segment_pattern_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OP_SET:     panel_q = render_number(number_i, point_position_i);
          OP_REFRESH: begin
            scans_due_q.push_back('{select: 3'(scan_pos_q), pattern: panel_q[scan_pos_q]});
            scan_pos_q = (scan_pos_q + 1) % DIGITS;
          end
          OP_CLEAR:   panel_q = {DIGITS{PAT_OFF}};
          default:    ;  // The unused code leaves everything as it is.
        endcase
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= scans_due_q.size();
    compared_o    <= compared;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number display testbench
// Drives set, refresh, clear and unused items into the display core with
// random gaps and output stalls, including a long output hold-off, and lets
// the scan checker compare every refresh result.
// ----------------------------------------------------------------------------
module testbench;
  import ssnd_pkg::*;

  localparam int         DIGITS         = 8;
  localparam int         CLK_PERIOD     = 8;
  localparam int         RESET_CYCLES   = 7;
  localparam int         RANDOM_ITEMS   = 700;
  localparam int         IDLE_PERCENT   = 19;
  localparam int         HOLD_CYCLES    = 80;
  localparam int         PRESSURE_BURST = 30;
  localparam int         LIMIT_CYCLES   = 400_000;
  localparam logic [1:0] OP_UNUSED      = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         op_i;
  logic signed [31:0] number_i;
  logic [3:0]         point_position_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         digit_select_o;
  logic [7:0]         segment_pattern_o;

  int mismatches;
  int outstanding;
  int compared;
  int holds_requested = 0;
  bit no_idle = 1'b0;
  int sets_sent;
  int refreshes_sent;
  int clears_sent;
  int ignored_sent;

  seven_segment_number_display_core #(
    .DIGITS(DIGITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .number_i         (number_i),
    .point_position_i (point_position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_select_o   (digit_select_o),
    .segment_pattern_o(segment_pattern_o)
  );

  ssnd_scan_checker #(
    .DIGITS(DIGITS)
  ) scan_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .number_i         (number_i),
    .point_position_i (point_position_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_select_i   (digit_select_o),
    .segment_pattern_i(segment_pattern_o),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .compared_o       (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Run timed out with %0d scan results outstanding", outstanding);
    $display("TEST FAILED");
    $finish;
  end

  // Magnitudes spread over every decimal length, with either sign.
  function automatic logic [31:0] pick_number();
    logic [31:0] mag;
    logic [31:0] lo;
    int unsigned digits;
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       mag = $urandom_range(0, 9);
      default: begin
        digits = $urandom_range(1, 10);
        lo     = 1;
        repeat (digits - 1) lo = lo * 10;
        mag = $urandom_range(lo, (digits == 10) ? 32'h7FFF_FFFF : lo * 10 - 1);
      end
    endcase
    return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
  endfunction

  function automatic logic [3:0] pick_point();
    return ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 7))
                                        : 4'($urandom_range(8, 15));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [31:0] number,
                           input logic [3:0] point);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    number_i         <= number;
    point_position_i <= point;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (op)
      OP_SET:     sets_sent++;
      OP_REFRESH: refreshes_sent++;
      OP_CLEAR:   clears_sent++;
      default:    ignored_sent++;
    endcase
  endtask

  // Output side: random stalls, plus one long hold-off when the stimulus asks.
  initial begin
    int holds_served;
    holds_served = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_requested > holds_served) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_served++;
      end
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  initial begin
    int counted;
    int burst;
    int roll;
    bit pressure_done;
    counted       = 0;
    pressure_done = 1'b0;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    op_i             <= OP_SET;
    number_i         <= '0;
    point_position_i <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: blank display after reset, zero, the most negative value
    // with truncation, a small negative value with a point and leading zeros,
    // an out-of-range point, a full-width value that leaves no room for the
    // sign, the unused code and a clear.
    send_item(OP_REFRESH, '0, '0);
    send_item(OP_SET, 32'd0, 4'd0);
    send_item(OP_SET, 32'h8000_0000, 4'd0);
    repeat (DIGITS) send_item(OP_REFRESH, 32'hFFFF_FFFF, 4'hF);
    send_item(OP_SET, -32'sd5, 4'd3);
    repeat (DIGITS) send_item(OP_REFRESH, '0, '0);
    send_item(OP_SET, 32'h7FFF_FFFF, 4'd15);
    send_item(OP_SET, -32'sd7, 4'd7);
    send_item(OP_UNUSED, 32'h5555_AAAA, 4'd9);
    send_item(OP_REFRESH, '0, '0);
    send_item(OP_CLEAR, 32'hAAAA_5555, 4'd6);
    send_item(OP_REFRESH, '0, '0);

    while (counted < RANDOM_ITEMS) begin
      if (!pressure_done && counted >= 450) begin
        // The output holds off while refreshes keep coming, so the result
        // buffer fills and the input has to stall.
        no_idle         <= 1'b1;
        holds_requested <= holds_requested + 1;
        repeat (PRESSURE_BURST) send_item(OP_REFRESH, $urandom(), 4'($urandom()));
        counted      += PRESSURE_BURST;
        pressure_done = 1'b1;
      end else begin
        no_idle <= (counted >= 250 && counted < 350);
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_item(OP_SET, pick_number(), pick_point());
          burst = $urandom_range(6, 10);
          repeat (burst) send_item(OP_REFRESH, $urandom(), 4'($urandom()));
          counted += burst + 1;
        end else if (roll < 80) begin
          send_item(OP_CLEAR, $urandom(), 4'($urandom()));
          counted++;
        end else if (roll < 88) begin
          send_item(OP_REFRESH, $urandom(), 4'($urandom()));
          counted++;
        end else if (roll < 95) begin
          send_item(OP_SET, pick_number(), pick_point());
          counted++;
        end else begin
          send_item(OP_UNUSED, $urandom(), 4'($urandom()));
        end
      end
    end

    in_valid_i <= 1'b0;
    no_idle    <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (2 * DIGITS + 8) @(posedge clk_i);

    $display("Sent %0d set, %0d refresh, %0d clear and %0d unused-code items,",
             sets_sent, refreshes_sent, clears_sent, ignored_sent);
    $display("with one long output hold-off; %0d scan results compared, %0d mismatches.",
             compared, mismatches);
    if (outstanding != 0) $display("%0d scan results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
